FILE: sv/lia_pkg.sv
// shared constants, types and the acos table builder for the incidence angle block
package lia_pkg;

   localparam int COORD_WIDTH_DEF  = 24;
   localparam int ACOS_ENTRIES_DEF = 1024;
   localparam int NORMAL_W         = 16;
   localparam int RANGE_W          = 25;
   localparam int COS_W            = 16;
   localparam int DEG_W            = 15;
   localparam int CSR_ADDR_W       = 2;
   localparam int QUEUE_DEPTH      = 4;
   localparam int CORDIC_STEPS     = 22;

   localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
   localparam logic [COS_W-1:0]   COS_CLAMP = 16'd65529;
   localparam longint             DEG90_Q8  = 23040;

   // atan(2^-k) in degrees, q.16
   localparam longint ATAN_DEG_Q16 [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCANNER_X = 2'd0,
      CSR_SCANNER_Y = 2'd1,
      CSR_SCANNER_Z = 2'd2
   } csr_index_type;

   // acos in degrees q7.8 of x/2^30, by a vectoring cordic on (x, sqrt(1 - x^2))
   function automatic logic [DEG_W-1:0] acos_entry(input longint x);
      longint y2;
      longint r;
      longint c;
      longint xv;
      longint yv;
      longint z;
      longint e;
      longint dx;
      longint dy;
      int     b;
      int     k;
      y2 = (longint'(1) <<< 60) - x * x;
      r  = 0;
      // root stays below 2^31, so higher trial bits never pass
      for (b = 30; b >= 0; b--) begin
         c = r | (longint'(1) <<< b);
         if (c * c <= y2) begin
            r = c;
         end
      end
      xv = x;
      yv = r;
      z  = 0;
      for (k = 0; k < CORDIC_STEPS; k++) begin
         dx = yv >>> k;
         dy = xv >>> k;
         if (yv >= 0) begin
            xv = xv + dx;
            yv = yv - dy;
            z  = z + ATAN_DEG_Q16[k];
         end else begin
            xv = xv - dx;
            yv = yv + dy;
            z  = z - ATAN_DEG_Q16[k];
         end
      end
      e = (z + 128) >>> 8;
      if (e < 0) begin
         e = 0;
      end
      if (e > DEG90_Q8) begin
         e = DEG90_Q8;
      end
      return e[DEG_W-1:0];
   endfunction

endpackage

FILE: sv/lidar_incidence_angle_top.sv
// top level of the lidar range and incidence angle block
//
//  channel   ports                     moves                          direction
//  req       req_push / req_full       point xyz and normal xyz       in
//  rsp       rsp_pop / rsp_empty       range, cosine, angle, invalid  out
//  csr       csr_we, csr_addr          scanner origin x, y, z         in
//
// one item enters and one result leaves per cycle at full rate, while rsp_pop keeps up.
// the delay from an accepted item to its result is set mostly by the
// one-bit-per-stage root and quotient pipelines.
// reset clears all valid flags and the scanner origin; no warm-up sweep.
// an unread result freezes the arithmetic pipe; the queue behind the front
// stage keeps taking items until it fills, then req_full rises.
module lidar_incidence_angle_top #(
   parameter int COORD_WIDTH        = lia_pkg::COORD_WIDTH_DEF,
   parameter int ACOS_TABLE_ENTRIES = lia_pkg::ACOS_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lia_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [COORD_WIDTH-1:0]              csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_x,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_y,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_z,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lia_pkg::RANGE_W-1:0]         rsp_range_to_scanner,
   output logic [lia_pkg::COS_W-1:0]           rsp_cos_incidence,
   output logic [lia_pkg::DEG_W-1:0]           rsp_incidence_deg,
   output logic                                rsp_point_invalid
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int NW = lia_pkg::NORMAL_W;
   localparam int QW = 3 * DW + 3 * NW + 1;

   logic                 fr_valid;
   logic                 q_full;
   logic signed [DW-1:0] fr_dx, fr_dy, fr_dz;
   logic signed [NW-1:0] fr_nx, fr_ny, fr_nz;
   logic                 fr_zero;
   logic [QW-1:0]        q_wdata;
   logic [QW-1:0]        q_rdata;
   logic                 q_empty;
   logic                 bk_ready;
   logic signed [DW-1:0] bk_dx, bk_dy, bk_dz;
   logic signed [NW-1:0] bk_nx, bk_ny, bk_nz;
   logic                 bk_zero;

   lia_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .req_normal_x (req_normal_x),
      .req_normal_y (req_normal_y),
      .req_normal_z (req_normal_z),
      .out_valid    (fr_valid),
      .out_full     (q_full),
      .out_dx       (fr_dx),
      .out_dy       (fr_dy),
      .out_dz       (fr_dz),
      .out_nx       (fr_nx),
      .out_ny       (fr_ny),
      .out_nz       (fr_nz),
      .out_zero     (fr_zero)
   );

   assign q_wdata = {fr_dx, fr_dy, fr_dz, fr_nx, fr_ny, fr_nz, fr_zero};

   lia_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fr_valid),
      .full  (q_full),
      .wdata (q_wdata),
      .pop   (bk_ready),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign {bk_dx, bk_dy, bk_dz, bk_nx, bk_ny, bk_nz, bk_zero} = q_rdata;

   lia_back #(
      .COORD_WIDTH        (COORD_WIDTH),
      .ACOS_TABLE_ENTRIES (ACOS_TABLE_ENTRIES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (!q_empty),
      .in_ready             (bk_ready),
      .in_dx                (bk_dx),
      .in_dy                (bk_dy),
      .in_dz                (bk_dz),
      .in_nx                (bk_nx),
      .in_ny                (bk_ny),
      .in_nz                (bk_nz),
      .in_zero              (bk_zero),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_range_to_scanner (rsp_range_to_scanner),
      .rsp_cos_incidence    (rsp_cos_incidence),
      .rsp_incidence_deg    (rsp_incidence_deg),
      .rsp_point_invalid    (rsp_point_invalid)
   );

endmodule

FILE: sv/lia_front.sv
// front stage: scanner registers, item intake, offset from scanner and zero check
module lia_front #(
   parameter int COORD_WIDTH = lia_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lia_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [COORD_WIDTH-1:0]              csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_x,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_y,
   input  logic signed [lia_pkg::NORMAL_W-1:0] req_normal_z,
   output logic                                out_valid,
   input  logic                                out_full,
   output logic signed [COORD_WIDTH:0]         out_dx,
   output logic signed [COORD_WIDTH:0]         out_dy,
   output logic signed [COORD_WIDTH:0]         out_dz,
   output logic signed [lia_pkg::NORMAL_W-1:0] out_nx,
   output logic signed [lia_pkg::NORMAL_W-1:0] out_ny,
   output logic signed [lia_pkg::NORMAL_W-1:0] out_nz,
   output logic                                out_zero
);

   localparam int DW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0]       sx_ff;
   logic signed [COORD_WIDTH-1:0]       sy_ff;
   logic signed [COORD_WIDTH-1:0]       sz_ff;
   logic                                vld_ff;
   logic                                vld_in;
   logic signed [DW-1:0]                dx_ff;
   logic signed [DW-1:0]                dy_ff;
   logic signed [DW-1:0]                dz_ff;
   logic signed [DW-1:0]                dx_in;
   logic signed [DW-1:0]                dy_in;
   logic signed [DW-1:0]                dz_in;
   logic signed [lia_pkg::NORMAL_W-1:0] nx_ff;
   logic signed [lia_pkg::NORMAL_W-1:0] ny_ff;
   logic signed [lia_pkg::NORMAL_W-1:0] nz_ff;
   logic                                zero_ff;
   logic                                zero_in;
   logic                                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0;
         sy_ff <= '0;
         sz_ff <= '0;
      end else if (csr_we) begin
         unique case (lia_pkg::csr_index_type'(csr_addr))
            lia_pkg::CSR_SCANNER_X: sx_ff <= csr_wdata;
            lia_pkg::CSR_SCANNER_Y: sy_ff <= csr_wdata;
            lia_pkg::CSR_SCANNER_Z: sz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = vld_ff && out_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      dx_in   = DW'(req_point_x) - DW'(sx_ff);
      dy_in   = DW'(req_point_y) - DW'(sy_ff);
      dz_in   = DW'(req_point_z) - DW'(sz_ff);
      // point sitting on the scanner has no direction
      zero_in = (req_point_x == sx_ff) && (req_point_y == sy_ff) && (req_point_z == sz_ff);
      vld_in  = accept || (vld_ff && out_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         nx_ff   <= req_normal_x;
         ny_ff   <= req_normal_y;
         nz_ff   <= req_normal_z;
         zero_ff <= zero_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_dx    = dx_ff;
   assign out_dy    = dy_ff;
   assign out_dz    = dz_ff;
   assign out_nx    = nx_ff;
   assign out_ny    = ny_ff;
   assign out_nz    = nz_ff;
   assign out_zero  = zero_ff;

endmodule

FILE: sv/lia_queue.sv
// short item queue between the front stage and the arithmetic pipeline
module lia_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] rdata
);

   localparam int DEPTH = lia_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: sv/lia_back.sv
// arithmetic pipeline: squares, dot product, root, quotient, acos lookup, result register
module lia_back #(
   parameter int COORD_WIDTH        = lia_pkg::COORD_WIDTH_DEF,
   parameter int ACOS_TABLE_ENTRIES = lia_pkg::ACOS_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [COORD_WIDTH:0]         in_dx,
   input  logic signed [COORD_WIDTH:0]         in_dy,
   input  logic signed [COORD_WIDTH:0]         in_dz,
   input  logic signed [lia_pkg::NORMAL_W-1:0] in_nx,
   input  logic signed [lia_pkg::NORMAL_W-1:0] in_ny,
   input  logic signed [lia_pkg::NORMAL_W-1:0] in_nz,
   input  logic                                in_zero,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lia_pkg::RANGE_W-1:0]         rsp_range_to_scanner,
   output logic [lia_pkg::COS_W-1:0]           rsp_cos_incidence,
   output logic [lia_pkg::DEG_W-1:0]           rsp_incidence_deg,
   output logic                                rsp_point_invalid
);

   localparam int CW    = COORD_WIDTH;
   localparam int DW    = CW + 1;
   localparam int SQW   = 2 * CW;
   localparam int SW    = 2 * CW + 2;
   localparam int RW    = CW + 1;
   localparam int PW    = CW + 17;
   localparam int DOTW  = CW + 19;
   localparam int MGW   = CW + 17;
   localparam int DVW   = CW + 18;
   localparam int QB    = lia_pkg::COS_W;
   localparam int IW    = $clog2(ACOS_TABLE_ENTRIES + 1);
   localparam int PRW   = QB + IW;
   localparam int DGW   = lia_pkg::DEG_W;
   localparam int RGW   = lia_pkg::RANGE_W;
   localparam int EXT_W = (RW > RGW) ? RW : RGW;
   localparam int MLW   = DGW + QB + 1;

   logic adv;

   // whole pipe moves when the result register can take a new value
   assign adv      = rsp_empty || rsp_pop;
   assign in_ready = adv;

   // ---------------- squares and normal products ----------------
   logic                 s1_vld_ff;
   logic [SQW-1:0]       s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic signed [PW-1:0] s1_prx_ff, s1_pry_ff, s1_prz_ff;
   logic                 s1_zero_ff;
   logic [CW-1:0]        ax_in, ay_in, az_in;
   logic signed [DW-1:0] ndx, ndy, ndz;

   always_comb begin
      ndx   = -in_dx;
      ndy   = -in_dy;
      ndz   = -in_dz;
      ax_in = in_dx[DW-1] ? ndx[CW-1:0] : in_dx[CW-1:0];
      ay_in = in_dy[DW-1] ? ndy[CW-1:0] : in_dy[CW-1:0];
      az_in = in_dz[DW-1] ? ndz[CW-1:0] : in_dz[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sqx_ff  <= SQW'(ax_in) * SQW'(ax_in);
         s1_sqy_ff  <= SQW'(ay_in) * SQW'(ay_in);
         s1_sqz_ff  <= SQW'(az_in) * SQW'(az_in);
         s1_prx_ff  <= PW'(in_nx) * PW'(in_dx);
         s1_pry_ff  <= PW'(in_ny) * PW'(in_dy);
         s1_prz_ff  <= PW'(in_nz) * PW'(in_dz);
         s1_zero_ff <= in_zero;
      end
   end

   // ---------------- sums, then one root bit per stage ----------------
   logic                   sq_vld_ff  [RW+1];
   logic [SW-1:0]          sq_rem_ff  [RW+1];
   logic [RW-1:0]          sq_root_ff [RW+1];
   logic [MGW-1:0]         sq_mag_ff  [RW+1];
   logic                   sq_zero_ff [RW+1];
   logic signed [DOTW-1:0] dot_in;
   logic signed [DOTW-1:0] ndot;
   logic [SW-1:0]          sum_in;
   logic [MGW-1:0]         mag_in;

   always_comb begin
      sum_in = SW'(s1_sqx_ff) + SW'(s1_sqy_ff) + SW'(s1_sqz_ff);
      dot_in = -(DOTW'(s1_prx_ff) + DOTW'(s1_pry_ff) + DOTW'(s1_prz_ff));
      ndot   = -dot_in;
      mag_in = dot_in[DOTW-1] ? ndot[MGW-1:0] : dot_in[MGW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= sum_in;
         sq_root_ff[0] <= '0;
         sq_mag_ff[0]  <= mag_in;
         sq_zero_ff[0] <= s1_zero_ff;
      end
   end

   for (genvar gk = 0; gk < RW; gk++) begin : g_sqrt
      localparam int B = RW - 1 - gk;
      logic [SW-1:0] trial;
      logic          take;
      logic [SW-1:0] rem_in;
      logic [RW-1:0] root_in;

      always_comb begin
         trial   = (SW'(sq_root_ff[gk]) << (B + 1)) | (SW'(1) << (2 * B));
         take    = (sq_rem_ff[gk] >= trial);
         rem_in  = take ? sq_rem_ff[gk] - trial : sq_rem_ff[gk];
         root_in = sq_root_ff[gk] | (RW'(take) << B);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[gk+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[gk+1] <= sq_vld_ff[gk];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[gk+1]  <= rem_in;
            sq_root_ff[gk+1] <= root_in;
            sq_mag_ff[gk+1]  <= sq_mag_ff[gk];
            sq_zero_ff[gk+1] <= sq_zero_ff[gk];
         end
      end
   end

   // ---------------- overflow check, then one quotient bit per stage ----------------
   logic           dv_vld_ff   [QB+1];
   logic [DVW-1:0] dv_rem_ff   [QB+1];
   logic [QB-1:0]  dv_q_ff     [QB+1];
   logic [RW-1:0]  dv_root_ff  [QB+1];
   logic           dv_over_ff  [QB+1];
   logic           dv_zero_ff  [QB+1];
   logic [RGW-1:0] dv_range_ff [QB+1];
   logic [DVW-1:0] num_in;
   logic           over_in;
   logic [EXT_W-1:0] r_ext;
   logic [RGW-1:0] range_in;

   always_comb begin
      num_in   = {sq_mag_ff[RW], 1'b0};
      // quotient of 2^16 or more means the cosine reached one
      over_in  = (num_in >= (DVW'(sq_root_ff[RW]) << QB));
      r_ext    = EXT_W'(sq_root_ff[RW]);
      range_in = (r_ext > EXT_W'(lia_pkg::RANGE_MAX)) ? lia_pkg::RANGE_MAX : r_ext[RGW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]   <= num_in;
         dv_q_ff[0]     <= '0;
         dv_root_ff[0]  <= sq_root_ff[RW];
         dv_over_ff[0]  <= over_in;
         dv_zero_ff[0]  <= sq_zero_ff[RW];
         dv_range_ff[0] <= range_in;
      end
   end

   for (genvar gm = 0; gm < QB; gm++) begin : g_div
      localparam int J = QB - 1 - gm;
      logic [DVW-1:0] trial;
      logic           take;
      logic [DVW-1:0] rem_in;
      logic [QB-1:0]  q_in;

      always_comb begin
         trial  = DVW'(dv_root_ff[gm]) << J;
         take   = (dv_rem_ff[gm] >= trial);
         rem_in = take ? dv_rem_ff[gm] - trial : dv_rem_ff[gm];
         q_in   = dv_q_ff[gm] | (QB'(take) << J);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[gm+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[gm+1] <= dv_vld_ff[gm];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[gm+1]   <= rem_in;
            dv_q_ff[gm+1]     <= q_in;
            dv_root_ff[gm+1]  <= dv_root_ff[gm];
            dv_over_ff[gm+1]  <= dv_over_ff[gm];
            dv_zero_ff[gm+1]  <= dv_zero_ff[gm];
            dv_range_ff[gm+1] <= dv_range_ff[gm];
         end
      end
   end

   // ---------------- table index and fraction ----------------
   logic           ix_vld_ff;
   logic [IW-1:0]  ix_idx_ff;
   logic [IW-1:0]  ix_idx1_ff;
   logic [QB-1:0]  ix_frac_ff;
   logic [QB-1:0]  ix_cos_ff;
   logic [RGW-1:0] ix_range_ff;
   logic           ix_zero_ff;
   logic [QB-1:0]  cos_in;
   logic [PRW-1:0] pos_in;
   logic [IW-1:0]  idx_raw;
   logic [IW-1:0]  idx_in;

   always_comb begin
      cos_in  = dv_over_ff[QB] ? lia_pkg::COS_CLAMP : dv_q_ff[QB];
      pos_in  = PRW'(cos_in) * PRW'(ACOS_TABLE_ENTRIES);
      idx_raw = pos_in[PRW-1:QB];
      idx_in  = (idx_raw >= IW'(ACOS_TABLE_ENTRIES)) ? IW'(ACOS_TABLE_ENTRIES - 1) : idx_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_vld_ff <= 1'b0;
      end else if (adv) begin
         ix_vld_ff <= dv_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ix_idx_ff   <= idx_in;
         ix_idx1_ff  <= idx_in + 1'b1;
         ix_frac_ff  <= pos_in[QB-1:0];
         ix_cos_ff   <= cos_in;
         ix_range_ff <= dv_range_ff[QB];
         ix_zero_ff  <= dv_zero_ff[QB];
      end
   end

   // ---------------- acos table read ----------------
   logic [DGW-1:0] acos_rom_w [ACOS_TABLE_ENTRIES+1];

   for (genvar gi = 0; gi <= ACOS_TABLE_ENTRIES; gi++) begin : g_rom
      localparam longint X = (longint'(gi) <<< 30) / ACOS_TABLE_ENTRIES;
      assign acos_rom_w[gi] = lia_pkg::acos_entry(X);
   end

   logic           rd_vld_ff;
   logic [DGW-1:0] rd_a_ff;
   logic [DGW-1:0] rd_b_ff;
   logic [QB-1:0]  rd_frac_ff;
   logic [QB-1:0]  rd_cos_ff;
   logic [RGW-1:0] rd_range_ff;
   logic           rd_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (adv) begin
         rd_vld_ff <= ix_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_a_ff     <= acos_rom_w[ix_idx_ff];
         rd_b_ff     <= acos_rom_w[ix_idx1_ff];
         rd_frac_ff  <= ix_frac_ff;
         rd_cos_ff   <= ix_cos_ff;
         rd_range_ff <= ix_range_ff;
         rd_zero_ff  <= ix_zero_ff;
      end
   end

   // ---------------- interpolation step ----------------
   logic           ml_vld_ff;
   logic [DGW-1:0] ml_a_ff;
   logic [DGW-1:0] ml_step_ff;
   logic           ml_down_ff;
   logic [QB-1:0]  ml_cos_ff;
   logic [RGW-1:0] ml_range_ff;
   logic           ml_zero_ff;
   logic           down_in;
   logic [DGW-1:0] gap_in;
   logic [MLW-1:0] scaled_in;

   always_comb begin
      down_in   = (rd_a_ff >= rd_b_ff);
      gap_in    = down_in ? rd_a_ff - rd_b_ff : rd_b_ff - rd_a_ff;
      // round to nearest on the dropped fraction bits
      scaled_in = MLW'(gap_in) * MLW'(rd_frac_ff) + (MLW'(1) << (QB - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_vld_ff <= 1'b0;
      end else if (adv) begin
         ml_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ml_a_ff     <= rd_a_ff;
         ml_step_ff  <= scaled_in[QB +: DGW];
         ml_down_ff  <= down_in;
         ml_cos_ff   <= rd_cos_ff;
         ml_range_ff <= rd_range_ff;
         ml_zero_ff  <= rd_zero_ff;
      end
   end

   // ---------------- result register ----------------
   logic           out_vld_ff;
   logic [RGW-1:0] out_range_ff;
   logic [QB-1:0]  out_cos_ff;
   logic [DGW-1:0] out_deg_ff;
   logic           out_inv_ff;
   logic [DGW-1:0] deg_in;

   always_comb begin
      deg_in = ml_down_ff ? ml_a_ff - ml_step_ff : ml_a_ff + ml_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= ml_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_range_ff <= ml_zero_ff ? '0 : ml_range_ff;
         out_cos_ff   <= ml_zero_ff ? '0 : ml_cos_ff;
         out_deg_ff   <= ml_zero_ff ? '0 : deg_in;
         out_inv_ff   <= ml_zero_ff;
      end
   end

   assign rsp_empty            = !out_vld_ff;
   assign rsp_range_to_scanner = out_range_ff;
   assign rsp_cos_incidence    = out_cos_ff;
   assign rsp_incidence_deg    = out_deg_ff;
   assign rsp_point_invalid    = out_inv_ff;

endmodule
